/* rtl/page_framebuffer_rotate_pack_top_assert.svh */
// Assertion macros used by the top RTL file of the page frame store block.
// Each macro takes a label, a property expression and a message string.
`ifndef PAGE_FRAMEBUFFER_ROTATE_PACK_TOP_ASSERT_SVH
`define PAGE_FRAMEBUFFER_ROTATE_PACK_TOP_ASSERT_SVH

`ifndef SYNTH

// Checked on every rising edge of aclk, suspended while reset is asserted.
`define PFRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, also during reset.
`define PFRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define PFRP_ASSERT(label, prop, msg)

`define PFRP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* rtl/pfrp_pkg.sv */
`default_nettype none

package pfrp_pkg;

    // Largest panel that the frame store covers.
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int PAGE_ROWS   = 8;
    localparam int PAGE_COUNT  = (MAX_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_DEPTH = MAX_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths of the channels.
    localparam int COORD_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int PAGE_W   = 3;
    localparam int WIDTH_W  = 8;
    localparam int HEIGHT_W = 7;

    // Signed working width of a remapped coordinate.
    localparam int SCOORD_W = 10;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROTATION     = 2'd0;
    localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd2;

    // Rotation codes.
    typedef enum logic [1:0] {
        ROT_0,
        ROT_90,
        ROT_180,
        ROT_270
    } rot_t;

endpackage

`default_nettype wire

/* rtl/page_framebuffer_rotate_pack_top.sv */
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      pixel_x, pixel_y, source_byte
// m_        out        m_valid / m_ready      page_index, column_index, page_byte,
//                                             out_of_range
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel is accepted per cycle while the pipeline is not stalled; its result passes
// through the input, store read and result registers in turn.
// The frame store has one write and one read port; back-to-back updates of
// the same byte are forwarded from the write stage to the read stage.
// After aresetn is released, a clearing pass zeroes the 1024-byte frame store,
// one byte per cycle, and s_ready stays low until the pass is done.
// With m_ready low the result holds; the pipeline fills and s_ready drops.
`default_nettype none

`include "page_framebuffer_rotate_pack_top_assert.svh"

module page_framebuffer_rotate_pack_top
    import pfrp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [WIDTH_W-1:0]  cfg_data,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [COORD_W-1:0]  s_pixel_x,
    input  wire logic [COORD_W-1:0]  s_pixel_y,
    input  wire logic [BYTE_W-1:0]   s_source_byte,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [PAGE_W-1:0]        m_page_index,
    output logic [COORD_W-1:0]       m_column_index,
    output logic [BYTE_W-1:0]        m_page_byte,
    output logic                     m_out_of_range
);

    // Configuration registers.
    rot_t                rotation_reg;
    logic [WIDTH_W-1:0]  panel_width_reg;
    logic [HEIGHT_W-1:0] panel_height_reg;

    // Clearing pass counter; the top bit marks the pass as done.
    logic [ADDR_W:0]     clr_cnt_reg;
    logic                clr_done;

    // Input stage.
    logic                a_valid_reg;
    logic [COORD_W-1:0]  a_x_reg;
    logic [COORD_W-1:0]  a_y_reg;
    logic [BYTE_W-1:0]   a_src_reg;

    // Read stage.
    logic                b_valid_reg;
    logic [ADDR_W-1:0]   b_addr_reg;
    logic [2:0]          b_bit_reg;
    logic                b_lit_reg;
    logic                b_oor_reg;
    logic [PAGE_W-1:0]   b_page_reg;
    logic [COORD_W-1:0]  b_col_reg;
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                fwd_sel_reg;
    logic [BYTE_W-1:0]   fwd_data_reg;

    // Result stage.
    logic                m_valid_reg;
    logic [PAGE_W-1:0]   m_page_reg;
    logic [COORD_W-1:0]  m_col_reg;
    logic [BYTE_W-1:0]   m_byte_reg;
    logic                m_oor_reg;

    // Frame store.
    logic [BYTE_W-1:0]   store_mem [STORE_DEPTH];

    // Pipeline flow control.
    logic out_free;
    logic b_go;
    logic b_free;
    logic a_go;
    logic a_free;
    logic s_take;

    // Remap and address of the item in the input stage.
    logic [WIDTH_W-1:0]         w_eff;
    logic [HEIGHT_W-1:0]        h_eff;
    logic signed [SCOORD_W-1:0] xp_s;
    logic signed [SCOORD_W-1:0] yp_s;
    logic                       a_oor;
    logic                       a_lit;
    logic [PAGE_W-1:0]          a_page;
    logic [ADDR_W-1:0]          a_prod;
    logic [ADDR_W-1:0]          a_addr;

    // Update of the item in the read stage.
    logic [BYTE_W-1:0] b_cur;
    logic [BYTE_W-1:0] b_mask;
    logic [BYTE_W-1:0] b_new;
    logic              b_wr;

    // Frame store write port.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [BYTE_W-1:0] mem_wd;

    assign clr_done  = clr_cnt_reg[ADDR_W];
    assign cfg_ready = 1'b1;

    // Each stage moves on when the one after it is empty or moving.
    assign out_free = !m_valid_reg || m_ready;
    assign b_go     = b_valid_reg && out_free;
    assign b_free   = !b_valid_reg || out_free;
    assign a_go     = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_ready  = a_free && clr_done;
    assign s_take   = s_valid && s_ready;

    // Panel size saturated to the store's dimensions.
    assign w_eff = (panel_width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                            : panel_width_reg;
    assign h_eff = (panel_height_reg > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT)
                                                               : panel_height_reg;

    // Coordinate remap; 90 and 270 degrees transpose and reflect, 0 and 180 pass through.
    always_comb begin
        xp_s = $signed({3'b000, a_x_reg});
        yp_s = $signed({3'b000, a_y_reg});
        case (rotation_reg) inside
            ROT_90: begin
                xp_s = $signed({2'b00, w_eff}) - SCOORD_W'(1)
                       - $signed({3'b000, a_y_reg});
                yp_s = $signed({3'b000, a_x_reg});
            end
            ROT_270: begin
                xp_s = $signed({3'b000, a_y_reg});
                yp_s = $signed({3'b000, h_eff}) - SCOORD_W'(1)
                       - $signed({3'b000, a_x_reg});
            end
            ROT_0, ROT_180: begin
                xp_s = $signed({3'b000, a_x_reg});
                yp_s = $signed({3'b000, a_y_reg});
            end
            default: begin
                xp_s = $signed({3'b000, a_x_reg});
                yp_s = $signed({3'b000, a_y_reg});
            end
        endcase
    end

    // Bounds check, page address and source pixel.
    assign a_oor  = xp_s[SCOORD_W-1] || yp_s[SCOORD_W-1]
                    || (xp_s[SCOORD_W-2:0] >= {1'b0, w_eff})
                    || (yp_s[SCOORD_W-2:0] >= {2'b00, h_eff});
    assign a_page = yp_s[PAGE_W+2:3];
    assign a_prod = ADDR_W'(w_eff) * ADDR_W'(a_page);
    assign a_addr = a_prod + ADDR_W'(xp_s[COORD_W-1:0]);
    assign a_lit  = a_src_reg[~a_x_reg[2:0]];

    // Inverted polarity: a set source bit clears the stored bit.
    assign b_cur  = fwd_sel_reg ? fwd_data_reg : rd_data_reg;
    assign b_mask = BYTE_W'(1) << b_bit_reg;
    assign b_new  = b_lit_reg ? (b_cur & ~b_mask) : (b_cur | b_mask);
    assign b_wr   = b_go && !b_oor_reg;

    // The clearing pass owns the write port until it is done.
    assign mem_we = !clr_done || b_wr;
    assign mem_wa = clr_done ? b_addr_reg : clr_cnt_reg[ADDR_W-1:0];
    assign mem_wd = clr_done ? b_new : '0;

    // Frame store with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_wa] <= mem_wd;
        end
        if (a_go) begin
            rd_data_reg <= store_mem[a_addr];
        end
    end

    // Control registers: configuration, clearing pass and stage valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg     <= ROT_0;
            panel_width_reg  <= WIDTH_W'(MAX_WIDTH);
            panel_height_reg <= HEIGHT_W'(MAX_HEIGHT);
            clr_cnt_reg      <= '0;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ROTATION:     rotation_reg     <= rot_t'(cfg_data[1:0]);
                    CFG_PANEL_WIDTH:  panel_width_reg  <= cfg_data;
                    CFG_PANEL_HEIGHT: panel_height_reg <= cfg_data[HEIGHT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (!clr_done) begin
                clr_cnt_reg <= clr_cnt_reg + (ADDR_W+1)'(1);
            end
            if (a_free) begin
                a_valid_reg <= s_take;
            end
            if (b_free) begin
                b_valid_reg <= a_go;
            end
            if (out_free) begin
                m_valid_reg <= b_go;
            end
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_x_reg   <= s_pixel_x;
            a_y_reg   <= s_pixel_y;
            a_src_reg <= s_source_byte;
        end
        if (a_go) begin
            b_addr_reg   <= a_addr;
            b_bit_reg    <= yp_s[2:0];
            b_lit_reg    <= a_lit;
            b_oor_reg    <= a_oor;
            b_page_reg   <= a_page;
            b_col_reg    <= xp_s[COORD_W-1:0];
            // The byte written this cycle is newer than the store's read data.
            fwd_sel_reg  <= b_wr && (b_addr_reg == a_addr);
            fwd_data_reg <= b_new;
        end
        if (b_go) begin
            m_page_reg <= b_oor_reg ? '0 : b_page_reg;
            m_col_reg  <= b_oor_reg ? '0 : b_col_reg;
            m_byte_reg <= b_oor_reg ? '0 : b_new;
            m_oor_reg  <= b_oor_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_page_index   = m_page_reg;
    assign m_column_index = m_col_reg;
    assign m_page_byte    = m_byte_reg;
    assign m_out_of_range = m_oor_reg;

    // No pixel enters while the store is still being cleared.
    `PFRP_ASSERT(a_no_take_in_clear, (s_valid && s_ready) |-> clr_done, "pixel taken during clear")

    // The pipeline is empty for the whole clearing pass.
    `PFRP_ASSERT_ALWAYS(a_empty_in_clear, (aresetn && !clr_done) |=> (!b_valid_reg && !m_valid_reg), "item in flight during clear")

    // Once done, the clearing pass stays done until the next reset.
    `PFRP_ASSERT(a_clear_sticky, clr_done |=> clr_done, "clearing pass restarted")

    // An off-panel result carries an all-zero payload.
    `PFRP_ASSERT(a_oor_zero, (m_valid && m_out_of_range) |-> (m_page_byte == '0 && m_column_index == '0 && m_page_index == '0), "off-panel result not zero")

    // An on-panel result lies within the effective panel width.
    `PFRP_ASSERT(a_col_in_panel, (m_valid && !m_out_of_range) |-> ({1'b0, m_column_index} < w_eff), "column outside panel")

endmodule

`default_nettype wire
